// ----- src/ssa_pkg.sv -----
// ssa_pkg: shared types and constants for the stepper steering block
// no dependencies; used by the channel interfaces and the top level
`default_nettype none
package ssa_pkg;

  localparam int POS_W   = 10;
  localparam int COIL_W  = 4;
  localparam int PHASE_W = 3;
  localparam int DIR_W   = 2;
  localparam int LAMP_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [COIL_W-1:0]  coil_t;
  typedef logic [PHASE_W-1:0] phase_t;
  typedef logic [DIR_W-1:0]   dir_t;
  typedef logic [LAMP_W-1:0]  lamp_t;

  // command codes
  localparam logic CMD_BUTTON = 1'b0;
  localparam logic CMD_MOTOR  = 1'b1;

  // direction codes
  localparam dir_t DIR_FWD  = 2'd0;
  localparam dir_t DIR_BACK = 2'd1;
  localparam dir_t DIR_HOLD = 2'd2;

  // lamp codes
  localparam lamp_t LAMP_NONE = 2'd0;
  localparam lamp_t LAMP_FWD  = 2'd1;
  localparam lamp_t LAMP_BACK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX    = 1'd1;

  localparam pos_t CENTER_RST = 10'd499;
  localparam pos_t MAX_RST    = 10'd998;

  // half-step coil sequence
  function automatic coil_t coil_lookup(input phase_t ph);
    coil_t c;
    unique case (ph)
      3'd0: c = 4'h1;
      3'd1: c = 4'h3;
      3'd2: c = 4'h2;
      3'd3: c = 4'h6;
      3'd4: c = 4'h4;
      3'd5: c = 4'hC;
      3'd6: c = 4'h8;
      3'd7: c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- src/ssa_if.sv -----
// ssa_if: valid/ready channel interfaces for button/motor items and results
// depends on ssa_pkg
`default_nettype none
interface ssa_in_if
  import ssa_pkg::*;
();
  logic valid;
  logic ready;
  logic command;
  logic forward_pressed;
  logic back_pressed;

  modport source (output valid, command, forward_pressed, back_pressed, input ready);
  modport sink   (input valid, command, forward_pressed, back_pressed, output ready);
endinterface

interface ssa_out_if
  import ssa_pkg::*;
();
  logic  valid;
  logic  ready;
  coil_t coil_pattern;
  lamp_t indicator;
  pos_t  position_now;
  logic  off_center;
  dir_t  direction_now;

  modport source (output valid, coil_pattern, indicator, position_now, off_center,
                  direction_now, input ready);
  modport sink   (input valid, coil_pattern, indicator, position_now, off_center,
                  direction_now, output ready);
endinterface
`default_nettype wire

// ----- src/stepper_steering_with_autocenter.sv -----
// stepper_steering_with_autocenter: half-step steering controller top level
// depends on ssa_pkg and the channel interfaces in ssa_if.sv
//
//   channel  dir  handshake        payload
//   in_ch    in   valid/ready      command, forward_pressed, back_pressed
//   out_ch   out  valid/ready      coil_pattern, indicator, position_now,
//                                  off_center, direction_now
//   cfg      in   cfg_we only      cfg_index, cfg_wdata (10 bits)
//
// one item per cycle unless out_ch stalls: an input register, then the state
// update and the result register, both written as an item leaves the input
// register, so a result is valid then and back-to-back items see each other
// an output stall fills the input register, then holds in_ch.ready low
// synchronous active-low reset: position to center, direction to hold
`default_nettype none
module stepper_steering_with_autocenter
  import ssa_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  ssa_in_if.sink                    in_ch,
  ssa_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [POS_W-1:0]     cfg_wdata
);

  // configuration
  pos_t center_r, max_r;

  // input register
  logic in_v_r;
  logic cmd_r, fwd_r, back_r;

  // block state
  logic   pushed_r, pushed_nxt;
  dir_t   dir_r, dir_nxt;
  phase_t phase_r, phase_nxt;
  pos_t   pos_r, pos_nxt;
  logic   ctr_r, ctr_nxt;
  coil_t  coil_r, coil_nxt;
  lamp_t  lamp_r, lamp_nxt;

  // result register
  logic out_v_r;

  logic advance;
  logic in_take;

  assign advance = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RST;
      max_r    <= MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER: center_r <= cfg_wdata;
        REG_MAX:    max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= in_ch.command;
      fwd_r  <= in_ch.forward_pressed;
      back_r <= in_ch.back_pressed;
    end
  end

  // next-state logic for one item
  always_comb begin
    logic only_fwd;
    logic only_back;
    pushed_nxt = pushed_r;
    dir_nxt    = dir_r;
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    ctr_nxt    = ctr_r;
    coil_nxt   = coil_r;
    lamp_nxt   = lamp_r;
    only_fwd   = fwd_r && !back_r;
    only_back  = back_r && !fwd_r;
    if (cmd_r == CMD_MOTOR) begin
      if (dir_r == DIR_FWD && pos_r < max_r) begin
        pos_nxt   = pos_r + POS_W'(1);
        ctr_nxt   = (pos_nxt != center_r);
        coil_nxt  = coil_lookup(phase_r);
        phase_nxt = phase_r + PHASE_W'(1);
      end else if (dir_r == DIR_BACK && pos_r != '0) begin
        pos_nxt   = pos_r - POS_W'(1);
        ctr_nxt   = (pos_nxt != center_r);
        coil_nxt  = coil_lookup(phase_r);
        phase_nxt = phase_r - PHASE_W'(1);
      end
    end else if (!pushed_r) begin
      priority if (only_fwd) begin
        pushed_nxt = 1'b1;
        lamp_nxt   = LAMP_FWD;
        dir_nxt    = DIR_FWD;
      end else if (only_back) begin
        pushed_nxt = 1'b1;
        lamp_nxt   = LAMP_BACK;
        dir_nxt    = DIR_BACK;
      end else begin
        lamp_nxt = LAMP_NONE;
        // steer back toward center when released
        if (ctr_r) dir_nxt = (pos_r < center_r) ? DIR_FWD : DIR_BACK;
        else       dir_nxt = DIR_HOLD;
      end
    end else begin
      priority if (only_fwd) begin
        lamp_nxt = LAMP_FWD;
      end else if (only_back) begin
        lamp_nxt = LAMP_BACK;
      end else begin
        pushed_nxt = 1'b0;
        lamp_nxt   = LAMP_NONE;
        dir_nxt    = DIR_HOLD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pushed_r <= 1'b0;
      dir_r    <= DIR_HOLD;
      phase_r  <= '0;
      pos_r    <= CENTER_RST;
      ctr_r    <= 1'b0;
      coil_r   <= '0;
      lamp_r   <= LAMP_NONE;
    end else if (advance) begin
      pushed_r <= pushed_nxt;
      dir_r    <= dir_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      ctr_r    <= ctr_nxt;
      coil_r   <= coil_nxt;
      lamp_r   <= lamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.coil_pattern  <= coil_nxt;
      out_ch.indicator     <= lamp_nxt;
      out_ch.position_now  <= pos_nxt;
      out_ch.off_center    <= ctr_nxt;
      out_ch.direction_now <= dir_nxt;
    end
  end

  assign out_ch.valid = out_v_r;

  // the lamp is lit exactly while a push is held
  a_lamp_push: assert property (@(posedge clk) disable iff (!rst_n)
    pushed_r == (lamp_r != LAMP_NONE))
    else $error("lamp and push state disagree");

  // a forward step that moves advances the position and the phase by one
  a_fwd_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && cmd_r == CMD_MOTOR && dir_r == DIR_FWD && pos_r < max_r
    |=> pos_r == $past(pos_r) + POS_W'(1) && phase_r == $past(phase_r) + PHASE_W'(1))
    else $error("forward step did not advance position and phase");

  // a new result only comes from a held input item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(in_v_r))
    else $error("result produced without an input item");

  // a stalled result register keeps the state frozen
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> $stable(pos_r) && $stable(dir_r) && $stable(pushed_r))
    else $error("state changed while the result was stalled");

endmodule
`default_nettype wire
